// ----- hw/rtl/kbl_pkg.sv -----
package kbl_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned KEY_W = 7;

  localparam logic [2:0] MODE_CHAR     = 3'd0;
  localparam logic [2:0] MODE_VKEY     = 3'd1;
  localparam logic [2:0] MODE_READ     = 3'd2;
  localparam logic [2:0] MODE_POP      = 3'd3;
  localparam logic [2:0] MODE_CAPS_TOG = 3'd4;
  localparam logic [2:0] MODE_CAPS_SET = 3'd5;

  localparam logic [7:0] VK_BREAK = 8'h03;
  localparam logic [7:0] VK_LEFT  = 8'h25;
  localparam logic [7:0] VK_DOWN  = 8'h28;
  localparam logic [7:0] VK_DEL   = 8'h2E;
  localparam logic [7:0] VK_F11   = 8'h7A;
  localparam logic [7:0] VK_F12   = 8'h7B;

  localparam logic [KEY_W-1:0] KEY_DEL = 7'h7F;

  typedef struct packed {
    logic             push;
    logic [KEY_W-1:0] key;
    logic             alt_toggle;
    logic             reset_req;
  } xlate_t;

  function automatic logic [KEY_W-1:0] arrow_map(input logic [1:0] idx);
    logic [KEY_W-1:0] r;
    case (idx)
      2'd0:    r = 7'h08;
      2'd1:    r = 7'h0B;
      2'd2:    r = 7'h15;
      default: r = 7'h0A;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] accent_map(input logic [7:0] k_in);
    logic [7:0] k;
    logic [7:0] r;
    k = k_in;
    if (k inside {[8'hC0:8'hDA]}) begin
      k = k + 8'h20;
    end
    case (k)
      8'hE0:   r = 8'h5F;
      8'hE1:   r = 8'h40;
      8'hE2:   r = 8'h5C;
      8'hE3:   r = 8'h5B;
      8'hE7:   r = 8'h5D;
      8'hE9:   r = 8'h60;
      8'hEA:   r = 8'h26;
      8'hED:   r = 8'h7B;
      8'hF3:   r = 8'h7E;
      8'hF4:   r = 8'h7D;
      8'hF5:   r = 8'h23;
      8'hFA:   r = 8'h7C;
      default: r = k;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/kbl_ram.sv -----
module kbl_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/kbl_xlate.sv -----
module kbl_xlate (
  input  logic [2:0]      mode_i,
  input  logic [7:0]      key_code_i,
  input  logic            ctrl_held_i,
  input  logic            caps_i,
  input  logic            alt_i,
  output kbl_pkg::xlate_t xl_o
);
  import kbl_pkg::*;

  logic [7:0] char_k;
  logic [7:0] char_up;

  always_comb begin
    char_k  = alt_i ? accent_map(key_code_i) : key_code_i;
    char_up = char_k;
    if (caps_i && (char_k inside {[8'h61:8'h7A]})) begin
      char_up = char_k - 8'h20;
    end

    xl_o = '0;
    case (mode_i)
      MODE_CHAR: begin
        xl_o.push = !char_k[7];
        xl_o.key  = char_up[KEY_W-1:0];
      end
      MODE_VKEY: begin
        if (ctrl_held_i && (key_code_i inside {VK_BREAK, VK_F12})) begin
          xl_o.reset_req = 1'b1;
        end else if (key_code_i == VK_F11) begin
          xl_o.alt_toggle = 1'b1;
        end else if (key_code_i == VK_DEL) begin
          xl_o.push = 1'b1;
          xl_o.key  = KEY_DEL;
        end else if (key_code_i inside {[VK_LEFT:VK_DOWN]}) begin
          xl_o.push = 1'b1;
          xl_o.key  = arrow_map(key_code_i[1:0] - 2'd1);
        end
      end
      default: begin
        xl_o = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/keyboard_latch_with_key_queue_top.sv -----
// Channel  Dir  tdata (low bit up)                              tuser
// s_axis   in   key_code[7:0], ctrl_held[8], caps_value[9]      mode[2:0]
// m_axis   out  read_value[7:0], key_waiting[8], caps_lock_on[9],
//               alt_mode_on[10], reset_request[11], queue_overflow[12]
//
// One item per cycle unless m_axis stalls; inputs and results are registered.
// The front key is prefetched from the key store's registered read port,
// addressed by the next read pointer, with a bypass for a same-cycle write.
// Reset empties the queue, clears strobe and alternate mode, sets caps lock.
// A stalled m_axis holds the result and the input register; s_axis stalls
// only when both are full.
module keyboard_latch_with_key_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // key_code, ctrl_held, caps_value
  input  logic [2:0]  s_axis_tuser_i,  // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // read_value, key_waiting, caps_lock_on,
                                       // alt_mode_on, reset_request, queue_overflow
);
  import kbl_pkg::*;

  logic             s1_valid_q;
  logic [2:0]       s1_mode_q;
  logic [7:0]       s1_key_q;
  logic             s1_ctrl_q;
  logic             s1_capv_q;

  logic             out_valid_q;
  logic [12:0]      out_data_q;

  logic [PTR_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [KEY_W-1:0] shown_q, shown_d;
  logic             strobe_q, strobe_d;
  logic             caps_q, caps_d;
  logic             alt_q, alt_d;
  logic             byp_q;
  logic [KEY_W-1:0] byp_data_q;

  logic             adv, fire, full, has_key, we, ovf;
  logic [KEY_W-1:0] ram_rdata, front;
  logic [PTR_W:0]   slot_sum;
  logic [PTR_W-1:0] wp, rp_inc;
  logic [7:0]       rv;
  xlate_t           xl;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign fire            = s1_valid_q && adv;
  assign s_axis_tready_o = !s1_valid_q || adv;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_data_q};

  kbl_xlate u_xlate (
    .mode_i      (s1_mode_q),
    .key_code_i  (s1_key_q),
    .ctrl_held_i (s1_ctrl_q),
    .caps_i      (caps_q),
    .alt_i       (alt_q),
    .xl_o        (xl)
  );

  kbl_ram #(
    .WIDTH (KEY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp),
    .wdata_i (xl.key),
    .raddr_i (rp_d),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    full     = count_q == CNT_W'(QUEUE_DEPTH);
    has_key  = count_q != '0;
    front    = has_key ? (byp_q ? byp_data_q : ram_rdata) : shown_q;
    slot_sum = (PTR_W+1)'(rp_q) + (PTR_W+1)'(count_q);
    wp       = (slot_sum >= (PTR_W+1)'(QUEUE_DEPTH))
               ? PTR_W'(slot_sum - (PTR_W+1)'(QUEUE_DEPTH)) : slot_sum[PTR_W-1:0];
    rp_inc   = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;

    rp_d     = rp_q;
    count_d  = count_q;
    shown_d  = shown_q;
    strobe_d = strobe_q;
    caps_d   = caps_q;
    alt_d    = alt_q;
    we       = 1'b0;
    ovf      = 1'b0;
    rv       = '0;

    if (fire) begin
      if (xl.push) begin
        if (full) begin
          ovf = 1'b1;
        end else begin
          we       = 1'b1;
          count_d  = count_q + 1'b1;
          strobe_d = 1'b1;
        end
      end
      if (xl.alt_toggle) begin
        alt_d = !alt_q;
      end
      case (s1_mode_q)
        MODE_READ: begin
          rv = {strobe_q, front};
        end
        MODE_POP: begin
          rv = {strobe_q, front};
          if (has_key) begin
            shown_d = front;
            rp_d    = rp_inc;
            count_d = count_q - 1'b1;
          end
          if (count_d == '0) begin
            strobe_d = 1'b0;
          end
        end
        MODE_CAPS_TOG: begin
          caps_d = !caps_q;
        end
        MODE_CAPS_SET: begin
          caps_d = s1_capv_q;
        end
        default: begin
          rv = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rp_q        <= '0;
      count_q     <= '0;
      shown_q     <= '0;
      strobe_q    <= 1'b0;
      caps_q      <= 1'b1;
      alt_q       <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      rp_q     <= rp_d;
      count_q  <= count_d;
      shown_q  <= shown_d;
      strobe_q <= strobe_d;
      caps_q   <= caps_d;
      alt_q    <= alt_d;
      byp_q    <= we && (wp == rp_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= xl.key;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_mode_q <= s_axis_tuser_i;
      s1_key_q  <= s_axis_tdata_i[7:0];
      s1_ctrl_q <= s_axis_tdata_i[8];
      s1_capv_q <= s_axis_tdata_i[9];
    end
    if (fire) begin
      out_data_q <= {ovf, xl.reset_req, alt_d, caps_d, strobe_d, rv};
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("key count above queue depth");

  a_rp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= PTR_W'(QUEUE_DEPTH - 1))
    else $error("read pointer out of range");

  a_strobe_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q == (count_q != '0))
    else $error("strobe disagrees with key count");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ovf) |-> full && !we)
    else $error("overflow without a full queue");

  a_reset_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && xl.reset_req) |=> $stable(count_q) && $stable(rp_q))
    else $error("reset request changed the queue");

endmodule

// ----- sim/keyboard_latch_with_key_queue_top_tb.sv -----
`timescale 1ns / 100ps

module keyboard_latch_with_key_queue_top_tb;

  import kbl_pkg::*;

  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
  localparam logic [7:0] VK_UP    = 8'h26;
  localparam logic [7:0] VK_RIGHT = 8'h27;
  localparam logic [7:0] VK_INS   = 8'h2D;

  typedef struct packed {
    logic       queue_overflow;
    logic       reset_request;
    logic       alt_mode_on;
    logic       caps_lock_on;
    logic       key_waiting;
    logic [7:0] read_value;
  } kbd_result_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] key;
    logic       ctrl;
    logic       capv;
  } kbd_cmd_t;

  typedef struct packed {
    kbd_cmd_t    cmd;
    logic        typed;
    kbd_result_t want;
  } kbd_row_t;

  typedef enum int unsigned {PH_FILL, PH_DRAIN, PH_MIXED} load_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;  // key_code, ctrl_held, caps_value
  logic [2:0]  s_axis_tuser_i = '0;  // mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;       // read_value, key_waiting, caps_lock_on,
                                     // alt_mode_on, reset_request, queue_overflow

  keyboard_latch_with_key_queue_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  logic [KEY_W-1:0] key_ring [QUEUE_DEPTH];
  int unsigned      ring_head;
  int unsigned      ring_fill;
  logic [KEY_W-1:0] last_front;
  logic             strobe_on;
  logic             caps_on;
  logic             alt_on;

  kbd_result_t pending_results [$];
  kbd_row_t    directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned send_wait_max = 11;
  int unsigned sink_wait_max = 11;

  function automatic kbd_result_t latch_step(input kbd_cmd_t c);
    kbd_result_t      r;
    logic [7:0]       k;
    logic [KEY_W-1:0] push_val;
    logic [KEY_W-1:0] front;
    logic             do_push;
    r = '0;
    k = c.key;
    do_push = 1'b0;
    push_val = '0;
    front = (ring_fill > 0) ? key_ring[ring_head] : last_front;
    case (c.mode)
      MODE_CHAR: begin
        if (alt_on) begin
          if (k >= 8'hC0 && k <= 8'hDA) k = k + 8'h20;
          case (k)
            8'hE0:   k = 8'h5F;
            8'hE1:   k = 8'h40;
            8'hE2:   k = 8'h5C;
            8'hE3:   k = 8'h5B;
            8'hE7:   k = 8'h5D;
            8'hE9:   k = 8'h60;
            8'hEA:   k = 8'h26;
            8'hED:   k = 8'h7B;
            8'hF3:   k = 8'h7E;
            8'hF4:   k = 8'h7D;
            8'hF5:   k = 8'h23;
            8'hFA:   k = 8'h7C;
            default: ;
          endcase
        end
        if (!k[7]) begin
          if (caps_on && k >= 8'h61 && k <= 8'h7A) k = k - 8'h20;
          do_push = 1'b1;
          push_val = k[KEY_W-1:0];
        end
      end
      MODE_VKEY: begin
        if ((c.key == VK_BREAK || c.key == VK_F12) && c.ctrl) begin
          r.reset_request = 1'b1;
        end else if (c.key == VK_F11) begin
          alt_on = ~alt_on;
        end else if (c.key == VK_DEL) begin
          do_push = 1'b1;
          push_val = KEY_DEL;
        end else if (c.key >= VK_LEFT && c.key <= VK_DOWN) begin
          do_push = 1'b1;
          case (c.key)
            VK_LEFT:  push_val = 7'h08;
            VK_UP:    push_val = 7'h0B;
            VK_RIGHT: push_val = 7'h15;
            default:  push_val = 7'h0A;
          endcase
        end
      end
      MODE_READ: begin
        r.read_value = {strobe_on, front};
      end
      MODE_POP: begin
        r.read_value = {strobe_on, front};
        if (ring_fill > 0) begin
          last_front = front;
          ring_head = (ring_head + 1) % QUEUE_DEPTH;
          ring_fill--;
        end
        if (ring_fill == 0) strobe_on = 1'b0;
      end
      MODE_CAPS_TOG: caps_on = ~caps_on;
      MODE_CAPS_SET: caps_on = c.capv;
      default: ;
    endcase
    if (do_push) begin
      if (ring_fill >= QUEUE_DEPTH) begin
        r.queue_overflow = 1'b1;
      end else begin
        key_ring[(ring_head + ring_fill) % QUEUE_DEPTH] = push_val;
        ring_fill++;
        strobe_on = 1'b1;
      end
    end
    r.key_waiting = strobe_on;
    r.caps_lock_on = caps_on;
    r.alt_mode_on = alt_on;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] m, input logic [7:0] k,
                                  input logic c, input logic v,
                                  input logic t = 1'b0, input kbd_result_t w = '0);
    directed_rows.push_back('{cmd: '{mode: m, key: k, ctrl: c, capv: v}, typed: t, want: w});
  endfunction

  function automatic kbd_cmd_t random_cmd(input load_phase_e phase);
    kbd_cmd_t    c;
    int unsigned roll;
    int unsigned char_lim, vkey_lim, pop_lim, read_lim;
    logic [7:0]  vkey_pick [9];
    vkey_pick = '{VK_BREAK, VK_F12, VK_F11, VK_DEL, VK_LEFT, VK_UP, VK_RIGHT,
                  VK_DOWN, VK_INS};
    case (phase)
      PH_FILL:  begin char_lim = 70; vkey_lim = 84; pop_lim = 90; read_lim = 95; end
      PH_DRAIN: begin char_lim = 12; vkey_lim = 20; pop_lim = 75; read_lim = 88; end
      default:  begin char_lim = 35; vkey_lim = 50; pop_lim = 70; read_lim = 85; end
    endcase
    c.key  = 8'($urandom_range(0, 255));
    c.ctrl = 1'($urandom_range(0, 1));
    c.capv = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < char_lim) begin
      c.mode = MODE_CHAR;
      roll = $urandom_range(0, 7);
      if (roll < 5) c.key = 8'($urandom_range(8'h20, 8'h7E));
      else if (roll == 5) c.key = 8'($urandom_range(8'hC0, 8'hFF));
    end else if (roll < vkey_lim) begin
      c.mode = MODE_VKEY;
      if ($urandom_range(0, 4) != 0) c.key = vkey_pick[$urandom_range(0, 8)];
    end else if (roll < pop_lim) begin
      c.mode = MODE_POP;
    end else if (roll < read_lim) begin
      c.mode = MODE_READ;
    end else begin
      c.mode = 3'($urandom_range(MODE_CAPS_TOG, MODE_UNUSED_7));
    end
    return c;
  endfunction

  task automatic send(input kbd_cmd_t c, input logic typed, input kbd_result_t want);
    int unsigned gap;
    kbd_result_t predicted;
    gap = $urandom_range(0, send_wait_max);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, c.capv, c.ctrl, c.key};
    s_axis_tuser_i  <= c.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = latch_step(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // sink side: stall a random number of cycles before each transfer
  initial begin : sink
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, sink_wait_max);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin : check_results
    kbd_result_t got;
    kbd_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = kbd_result_t'(m_axis_tdata_o[12:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result tdata=%04h", $realtime, m_axis_tdata_o);
      end else begin
        want = pending_results.pop_front();
        if (got.read_value !== want.read_value || got.key_waiting !== want.key_waiting ||
            got.caps_lock_on !== want.caps_lock_on || got.alt_mode_on !== want.alt_mode_on ||
            got.reset_request !== want.reset_request ||
            got.queue_overflow !== want.queue_overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch expected rv=%02h kw=%b caps=%b alt=%b rst=%b ovf=%b",
                     $realtime,
                     want.read_value, want.key_waiting, want.caps_lock_on,
                     want.alt_mode_on, want.reset_request, want.queue_overflow,
                     " got rv=%02h kw=%b caps=%b alt=%b rst=%b ovf=%b",
                     got.read_value, got.key_waiting, got.caps_lock_on,
                     got.alt_mode_on, got.reset_request, got.queue_overflow);
        end
      end
    end
  end

  initial begin : stimulus
    load_phase_e phase;
    ring_head  = 0;
    ring_fill  = 0;
    last_front = '0;
    strobe_on  = 1'b0;
    caps_on    = 1'b1;
    alt_on     = 1'b0;

    add_row(MODE_READ, 8'h00, 1'b0, 1'b0, 1'b1,
            '{read_value: 8'h00, key_waiting: 1'b0, caps_lock_on: 1'b1,
              alt_mode_on: 1'b0, reset_request: 1'b0, queue_overflow: 1'b0});
    add_row(MODE_POP, 8'hFF, 1'b1, 1'b1, 1'b1,
            '{read_value: 8'h00, key_waiting: 1'b0, caps_lock_on: 1'b1,
              alt_mode_on: 1'b0, reset_request: 1'b0, queue_overflow: 1'b0});
    add_row(MODE_CHAR, 8'h61, 1'b0, 1'b0);
    add_row(MODE_READ, 8'h00, 1'b0, 1'b0, 1'b1,
            '{read_value: 8'hC1, key_waiting: 1'b1, caps_lock_on: 1'b1,
              alt_mode_on: 1'b0, reset_request: 1'b0, queue_overflow: 1'b0});
    add_row(MODE_CAPS_SET, 8'h00, 1'b0, 1'b0);
    add_row(MODE_CHAR, 8'h7A, 1'b0, 1'b0);
    add_row(MODE_CHAR, 8'h80, 1'b0, 1'b0);
    add_row(MODE_CHAR, 8'hFF, 1'b0, 1'b0);
    add_row(MODE_CHAR, 8'h00, 1'b0, 1'b0);
    add_row(MODE_VKEY, VK_F11, 1'b0, 1'b0);
    add_row(MODE_CHAR, 8'hC0, 1'b0, 1'b0);
    add_row(MODE_CHAR, 8'hDA, 1'b0, 1'b0);
    add_row(MODE_CHAR, 8'hE7, 1'b0, 1'b0);
    add_row(MODE_CHAR, 8'hFF, 1'b0, 1'b0);
    add_row(MODE_VKEY, VK_DEL, 1'b0, 1'b0);
    add_row(MODE_VKEY, VK_LEFT, 1'b0, 1'b0);
    add_row(MODE_VKEY, VK_DOWN, 1'b0, 1'b0);
    add_row(MODE_VKEY, VK_INS, 1'b1, 1'b0);
    add_row(MODE_VKEY, VK_F12, 1'b1, 1'b0);
    add_row(MODE_VKEY, VK_BREAK, 1'b1, 1'b0);
    add_row(MODE_VKEY, VK_BREAK, 1'b0, 1'b0);
    add_row(MODE_VKEY, VK_F11, 1'b1, 1'b0);
    add_row(MODE_CAPS_TOG, 8'h00, 1'b0, 1'b0);
    add_row(MODE_POP, 8'h00, 1'b0, 1'b0);
    add_row(MODE_UNUSED_6, 8'hFF, 1'b1, 1'b1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // fill first so the queue runs full, then wander between loads
    for (int seg = 0; seg < 10; seg++) begin
      phase = (seg < 2) ? PH_FILL : load_phase_e'($urandom_range(0, 2));
      send_wait_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      sink_wait_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      for (int n = 0; n < 145; n++) send(random_cmd(phase), 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("keyboard_latch_with_key_queue_top_tb: clean");
    end else begin
      $display("keyboard_latch_with_key_queue_top_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("keyboard_latch_with_key_queue_top_tb: errors");
    $finish;
  end

endmodule
